// ===== hdl/fpa_pkg.sv =====
// Shared types, constants and helpers of the fixed-point ALU.
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int RAW_W     = 32;
    localparam int QUO_W     = RAW_W + FRAC_BITS;
    localparam int PROD_W    = 2 * RAW_W;

    localparam logic [RAW_W-1:0]  RAW_MAX = {1'b0, {(RAW_W-1){1'b1}}};
    localparam logic [RAW_W-1:0]  RAW_MIN = {1'b1, {(RAW_W-1){1'b0}}};
    localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [PROD_W-1:0] POS_LIMIT = PROD_W'(RAW_MAX);
    localparam logic [PROD_W-1:0] NEG_LIMIT = PROD_W'(RAW_MIN);

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_INC      = 4'd6,
        OP_DEC      = 4'd7,
        OP_FROM_INT = 4'd8,
        OP_TO_INT   = 4'd9
    } op_t;

    // Everything that rides alongside the divider stages.
    typedef struct packed {
        op_t                op;
        logic [RAW_W-1:0]   simple_res;
        logic               simple_ovf;
        logic               dz;
        logic               gt;
        logic               lt;
        logic               eq;
        logic [PROD_W-1:0]  prod;
        logic               qneg;
    } side_t;

    // Saturates a 33-bit two's complement sum; bit 32 of the result is the overflow flag.
    function automatic logic [RAW_W:0] sat_33(input logic [RAW_W:0] v);
        logic ovf;
        logic [RAW_W-1:0] r;
        ovf = v[RAW_W] != v[RAW_W-1];
        r = ovf ? (v[RAW_W] ? RAW_MIN : RAW_MAX) : v[RAW_W-1:0];
        return {ovf, r};
    endfunction

endpackage

// ===== hdl/fpa_if.sv =====
// Valid/ready channel interfaces for requests and responses of the ALU.
interface fpa_req_if;
    import fpa_pkg::*;
    logic             valid;
    logic             ready;
    logic [3:0]       opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;

    modport source (output valid, opcode, operand_a, operand_b, input ready);
    modport sink   (input valid, opcode, operand_a, operand_b, output ready);
endinterface

interface fpa_rsp_if;
    logic             valid;
    logic             ready;
    logic signed [31:0] result_raw;
    logic             a_greater;
    logic             a_less;
    logic             a_equal;
    logic             overflowed;
    logic             div_by_zero;

    modport source (output valid, result_raw, a_greater, a_less, a_equal, overflowed,
                    div_by_zero, input ready);
    modport sink   (input valid, result_raw, a_greater, a_less, a_equal, overflowed,
                    div_by_zero, output ready);
endinterface

// ===== hdl/fixed_point_alu.sv =====
// Top level of the signed fixed-point ALU.
// Fixed-point ALU on 32-bit raw values with FRAC_BITS fraction bits (Q24.8).
// It accepts one beat every cycle while the response side does not stall, and returns one
// result beat per request, in order. The divider resolves one quotient bit per pipeline
// stage. Every operation runs through the same pipeline, and the whole pipe holds when the
// response side stalls. Multiply and divide round to nearest, ties away from zero; results
// out of range saturate and raise overflowed.
module fixed_point_alu
    import fpa_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    fpa_req_if.sink      req,
    fpa_rsp_if.source    rsp
);

    logic adv;

    // Stage 1: input registers.
    logic                v1_reg;
    logic [3:0]          op1_reg;
    logic signed [31:0]  a1_reg;
    logic signed [31:0]  b1_reg;

    // Stage 2: product, simple results and divider operands.
    logic                v2_reg;
    side_t               side2_reg;
    side_t               side2_next;
    logic [QUO_W-1:0]    num2_reg;
    logic [QUO_W-1:0]    num2_next;
    logic [RAW_W-1:0]    den2_reg;
    logic [RAW_W-1:0]    den2_next;

    // Divider outputs.
    logic                vd;
    logic [QUO_W-1:0]    quo_d;
    logic [RAW_W-1:0]    rem_d;
    logic [RAW_W-1:0]    den_d;
    side_t               side_d;

    // Rounding stage.
    logic                v3_reg;
    side_t               side3_reg;
    logic [PROD_W-1:0]   mag3_reg;
    logic [PROD_W-1:0]   mag3_next;
    logic                neg3_reg;
    logic                neg3_next;
    logic                rnd3_reg;
    logic                rnd3_next;

    // Output stage.
    logic                v4_reg;
    logic [RAW_W-1:0]    res4_reg;
    logic [RAW_W-1:0]    res4_next;
    logic                ovf4_reg;
    logic                ovf4_next;
    logic                gt4_reg;
    logic                lt4_reg;
    logic                eq4_reg;
    logic                dz4_reg;

    assign adv       = !v4_reg || rsp.ready;
    assign req.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req.valid;
            v2_reg <= v1_reg;
            v3_reg <= vd;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg   <= req.opcode;
            a1_reg    <= req.operand_a;
            b1_reg    <= req.operand_b;
            side2_reg <= side2_next;
            num2_reg  <= num2_next;
            den2_reg  <= den2_next;
            side3_reg <= side_d;
            mag3_reg  <= mag3_next;
            neg3_reg  <= neg3_next;
            rnd3_reg  <= rnd3_next;
            res4_reg  <= res4_next;
            ovf4_reg  <= ovf4_next;
            gt4_reg   <= side3_reg.gt;
            lt4_reg   <= side3_reg.lt;
            eq4_reg   <= side3_reg.eq;
            dz4_reg   <= side3_reg.dz;
        end
    end

    // Stage 2 logic.
    always_comb
    begin
        logic [RAW_W:0]     s_add;
        logic [RAW_W:0]     s_sub;
        logic [RAW_W:0]     s_inc;
        logic [RAW_W:0]     s_dec;
        logic [RAW_W:0]     sat;
        logic [FRAC_BITS:0] hi;
        logic               fi_ovf;
        logic [RAW_W-1:0]   mag_a;
        logic [RAW_W-1:0]   mag_b;
        logic [RAW_W-1:0]   sat_a;

        s_add = {a1_reg[31], a1_reg} + {b1_reg[31], b1_reg};
        s_sub = {a1_reg[31], a1_reg} - {b1_reg[31], b1_reg};
        s_inc = {a1_reg[31], a1_reg} + (RAW_W+1)'(1);
        s_dec = {a1_reg[31], a1_reg} - (RAW_W+1)'(1);
        hi    = a1_reg[RAW_W-1:RAW_W-1-FRAC_BITS];
        fi_ovf = !((hi == '0) || (hi == '1));
        sat_a = a1_reg[31] ? RAW_MIN : RAW_MAX;
        mag_a = a1_reg[31] ? (RAW_W)'(-a1_reg) : a1_reg;
        mag_b = b1_reg[31] ? (RAW_W)'(-b1_reg) : b1_reg;

        side2_next            = '0;
        side2_next.op         = op_t'(op1_reg);
        side2_next.gt         = a1_reg > b1_reg;
        side2_next.lt         = a1_reg < b1_reg;
        side2_next.eq         = a1_reg == b1_reg;
        side2_next.prod       = PROD_W'(a1_reg * b1_reg);
        side2_next.qneg       = a1_reg[31] ^ b1_reg[31];
        sat                   = '0;

        unique case (op_t'(op1_reg))
            OP_ADD:
            begin
                sat = sat_33(s_add);
            end
            OP_SUB:
            begin
                sat = sat_33(s_sub);
            end
            OP_INC:
            begin
                sat = sat_33(s_inc);
            end
            OP_DEC:
            begin
                sat = sat_33(s_dec);
            end
            OP_DIV:
            begin
                side2_next.dz = b1_reg == '0;
                sat = {1'b0, sat_a};
            end
            OP_MIN:
            begin
                sat = {1'b0, (b1_reg < a1_reg) ? b1_reg : a1_reg};
            end
            OP_MAX:
            begin
                sat = {1'b0, (a1_reg < b1_reg) ? b1_reg : a1_reg};
            end
            OP_FROM_INT:
            begin
                sat = {fi_ovf, fi_ovf ? sat_a : (a1_reg <<< FRAC_BITS)};
            end
            OP_TO_INT:
            begin
                sat = {1'b0, RAW_W'(a1_reg >>> FRAC_BITS)};
            end
            default:
            begin
                sat = '0;
            end
        endcase

        side2_next.simple_res = sat[RAW_W-1:0];
        side2_next.simple_ovf = sat[RAW_W];
        num2_next = {mag_a, {FRAC_BITS{1'b0}}};
        den2_next = mag_b;
    end

    fpa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (v2_reg),
        .in_num    (num2_reg),
        .in_den    (den2_reg),
        .in_side   (side2_reg),
        .out_valid (vd),
        .out_quo   (quo_d),
        .out_rem   (rem_d),
        .out_den   (den_d),
        .out_side  (side_d)
    );

    // Rounding: magnitudes of the multiply and divide results before saturation.
    always_comb
    begin
        logic [RAW_W:0]   rem2;
        logic             up;
        logic [PROD_W-1:0] m_mul;

        rem2  = {rem_d, 1'b0};
        up    = rem2 >= {1'b0, den_d};
        m_mul = side_d.prod[PROD_W-1] ? (HALF_LSB - side_d.prod) : (side_d.prod + HALF_LSB);

        if (side_d.op == OP_MUL)
        begin
            mag3_next = m_mul >> FRAC_BITS;
            neg3_next = side_d.prod[PROD_W-1];
        end
        else
        begin
            mag3_next = PROD_W'(quo_d) + PROD_W'(up);
            neg3_next = side_d.qneg;
        end
        rnd3_next = (side_d.op == OP_MUL) || ((side_d.op == OP_DIV) && !side_d.dz);
    end

    // Saturation and final selection.
    always_comb
    begin
        logic ovf;
        if (rnd3_reg)
        begin
            ovf = neg3_reg ? (mag3_reg > NEG_LIMIT) : (mag3_reg > POS_LIMIT);
            if (ovf)
            begin
                res4_next = neg3_reg ? RAW_MIN : RAW_MAX;
            end
            else
            begin
                res4_next = neg3_reg ? (RAW_W)'(-mag3_reg[RAW_W-1:0]) : mag3_reg[RAW_W-1:0];
            end
            ovf4_next = ovf;
        end
        else
        begin
            ovf       = side3_reg.simple_ovf;
            res4_next = side3_reg.simple_res;
            ovf4_next = ovf;
        end
    end

    assign rsp.valid       = v4_reg;
    assign rsp.result_raw  = res4_reg;
    assign rsp.a_greater   = gt4_reg;
    assign rsp.a_less      = lt4_reg;
    assign rsp.a_equal     = eq4_reg;
    assign rsp.overflowed  = ovf4_reg;
    assign rsp.div_by_zero = dz4_reg;

endmodule

// ===== hdl/fpa_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
module fpa_div
    import fpa_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  logic               in_valid,
    input  logic [QUO_W-1:0]   in_num,
    input  logic [RAW_W-1:0]   in_den,
    input  side_t              in_side,
    output logic               out_valid,
    output logic [QUO_W-1:0]   out_quo,
    output logic [RAW_W-1:0]   out_rem,
    output logic [RAW_W-1:0]   out_den,
    output side_t              out_side
);

    logic               v_reg    [QUO_W];
    logic [QUO_W-1:0]   num_reg  [QUO_W];
    logic [QUO_W-1:0]   quo_reg  [QUO_W];
    logic [RAW_W-1:0]   rem_reg  [QUO_W];
    logic [RAW_W-1:0]   den_reg  [QUO_W];
    side_t              side_reg [QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic               p_v;
        logic [QUO_W-1:0]   p_num;
        logic [QUO_W-1:0]   p_quo;
        logic [RAW_W-1:0]   p_rem;
        logic [RAW_W-1:0]   p_den;
        side_t              p_side;
        logic [RAW_W:0]     trial;
        logic [RAW_W:0]     diff;
        logic               ge;
        logic [RAW_W-1:0]   rem_next;
        logic [QUO_W-1:0]   quo_next;

        if (k == 0) begin : g_first
            assign p_v    = in_valid;
            assign p_num  = in_num;
            assign p_quo  = '0;
            assign p_rem  = '0;
            assign p_den  = in_den;
            assign p_side = in_side;
        end
        else begin : g_rest
            assign p_v    = v_reg[k-1];
            assign p_num  = num_reg[k-1];
            assign p_quo  = quo_reg[k-1];
            assign p_rem  = rem_reg[k-1];
            assign p_den  = den_reg[k-1];
            assign p_side = side_reg[k-1];
        end

        // For a nonzero divisor the partial remainder stays below it, so it always fits 32 bits.
        always_comb
        begin
            trial = {p_rem, p_num[QUO_W-1-k]};
            diff  = trial - {1'b0, p_den};
            ge    = trial >= {1'b0, p_den};
            rem_next = ge ? diff[RAW_W-1:0] : trial[RAW_W-1:0];
            quo_next = p_quo;
            quo_next[QUO_W-1-k] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= p_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                num_reg[k]  <= p_num;
                quo_reg[k]  <= quo_next;
                rem_reg[k]  <= rem_next;
                den_reg[k]  <= p_den;
                side_reg[k] <= p_side;
            end
        end
    end

    assign out_valid = v_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_rem   = rem_reg[QUO_W-1];
    assign out_den   = den_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

// ===== bench/fixed_point_alu_test.sv =====
// Testbench for the fixed-point ALU: random and directed operations checked against a predictor.
`timescale 1ns / 100ps

module fixed_point_alu_test;
    import fpa_pkg::*;

    typedef struct {
        logic [3:0]         opcode;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } alu_op_t;

    typedef struct {
        logic signed [31:0] res;
        logic gt, lt, eq, ovf, dz;
    } alu_res_t;

    localparam longint LMAX = 64'sd2147483647;
    localparam longint LMIN = -64'sd2147483648;
    localparam int LATENCY = FRAC_BITS + 35;

    logic clk;
    logic rst_n;
    fpa_req_if req ();
    fpa_rsp_if rsp ();

    fixed_point_alu DUT (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_sender;
    int mismatches;
    int ops_sent;
    int results_seen;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint saturate(longint v, ref bit ovf);
        if (v > LMAX)
        begin
            ovf = 1'b1;
            return LMAX;
        end
        if (v < LMIN)
        begin
            ovf = 1'b1;
            return LMIN;
        end
        return v;
    endfunction

    function automatic alu_res_t predict_alu(alu_op_t op);
        alu_res_t r;
        longint a, b, v, p, q, rem;
        longint unsigned m, num, den;
        bit ovf;
        bit neg;
        a = op.a;
        b = op.b;
        v = 0;
        ovf = 1'b0;
        r.dz = 1'b0;
        case (op.opcode)
            OP_ADD: v = saturate(a + b, ovf);
            OP_SUB: v = saturate(a - b, ovf);
            OP_MUL:
            begin
                p = a * b;
                m = (p < 0) ? -p : p;
                m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                q = (p < 0) ? -longint'(m) : longint'(m);
                v = saturate(q, ovf);
            end
            OP_DIV:
            begin
                if (b == 0)
                begin
                    r.dz = 1'b1;
                    v = (a < 0) ? LMIN : LMAX;
                end
                else
                begin
                    num = ((a < 0) ? -a : a);
                    num = num << FRAC_BITS;
                    den = (b < 0) ? -b : b;
                    m = num / den;
                    rem = num % den;
                    if (rem >= den - rem)
                        m++;
                    neg = (a < 0) != (b < 0);
                    v = saturate(neg ? -longint'(m) : longint'(m), ovf);
                end
            end
            OP_MIN: v = (b < a) ? b : a;
            OP_MAX: v = (a < b) ? b : a;
            OP_INC: v = saturate(a + 1, ovf);
            OP_DEC: v = saturate(a - 1, ovf);
            OP_FROM_INT: v = saturate(a * (64'sd1 <<< FRAC_BITS), ovf);
            OP_TO_INT: v = a >>> FRAC_BITS;
            default: v = 0;
        endcase
        r.res = v[31:0];
        r.gt = a > b;
        r.lt = a < b;
        r.eq = a == b;
        r.ovf = ovf;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("ERROR at %0t: result %0d field %s got %0h expected %0h",
                 $realtime, results_seen, what, got, want);
        mismatches++;
    endtask

    // Driver: at most one nonblocking update of valid per edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            req.opcode <= '0;
            req.operand_a <= '0;
            req.operand_b <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                expected_results.push_back(predict_alu('{req.opcode, req.operand_a,
                                                         req.operand_b}));
                ops_sent++;
            end
            if (!req.valid || req.ready)
            begin
                if (pending_ops.size() > 0 && !hold_sender
                    && $urandom_range(99) >= send_idle_pct)
                begin
                    alu_op_t op;
                    op = pending_ops.pop_front();
                    req.valid <= 1'b1;
                    req.opcode <= op.opcode;
                    req.operand_a <= op.a;
                    req.operand_b <= op.b;
                end
                else
                    req.valid <= 1'b0;
            end
        end
    end

    // Monitor and response-side stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    $display("ERROR at %0t: result beat with nothing expected", $realtime);
                    mismatches++;
                end
                else
                begin
                    alu_res_t e;
                    e = expected_results.pop_front();
                    if (rsp.result_raw !== e.res)
                        report_mismatch("result_raw", rsp.result_raw, e.res);
                    if (rsp.a_greater !== e.gt)
                        report_mismatch("a_greater", rsp.a_greater, e.gt);
                    if (rsp.a_less !== e.lt)
                        report_mismatch("a_less", rsp.a_less, e.lt);
                    if (rsp.a_equal !== e.eq)
                        report_mismatch("a_equal", rsp.a_equal, e.eq);
                    if (rsp.overflowed !== e.ovf)
                        report_mismatch("overflowed", rsp.overflowed, e.ovf);
                    if (rsp.div_by_zero !== e.dz)
                        report_mismatch("div_by_zero", rsp.div_by_zero, e.dz);
                end
            end
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(7))
            0: return 32'sh7FFFFFFF - $urandom_range(3);
            1: return 32'sh80000000 + $urandom_range(3);
            2: return $urandom_range(4) - 2;
            3: return $signed($urandom_range(65535)) - 32768;
            4: return $signed($urandom_range(16777215)) - 8388608;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(logic [3:0] opc, logic signed [31:0] a, logic signed [31:0] b);
        pending_ops.push_back('{opc, a, b});
    endtask

    task automatic add_random(int count);
        logic [3:0] opc;
        logic signed [31:0] a, b;
        for (int i = 0; i < count; i++)
        begin
            opc = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                           : 4'($urandom_range(9));
            a = pick_operand();
            b = ($urandom_range(9) == 0) ? a : pick_operand();
            if (opc == OP_DIV && $urandom_range(9) == 0)
                b = 0;
            add_op(opc, a, b);
        end
    endtask

    task automatic drain_all();
        while (pending_ops.size() > 0 || req.valid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        send_idle_pct = 28;
        recv_idle_pct = 61;
        hold_sender = 1'b0;
        mismatches = 0;
        ops_sent = 0;
        results_seen = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every operation, divide by zero, saturation, odd opcodes.
        add_op(OP_ADD, 32'sh7FFFFFFF, 32'sh1);
        add_op(OP_SUB, 32'sh80000000, 32'sh1);
        add_op(OP_MUL, 32'sh80000000, 32'sh80000000);
        add_op(OP_MUL, 32'sh180, 32'sh1);
        add_op(OP_MUL, -32'sh180, 32'sh1);
        add_op(OP_DIV, 32'sh100, 32'sh0);
        add_op(OP_DIV, -32'sh100, 32'sh0);
        add_op(OP_DIV, 32'sh7FFFFFFF, 32'sh1);
        add_op(OP_DIV, 32'sh80000000, -32'sh1);
        add_op(OP_DIV, 32'sh80, -32'sh100);
        add_op(OP_MIN, 32'sh80000000, 32'sh7FFFFFFF);
        add_op(OP_MAX, 32'sh80000000, 32'sh7FFFFFFF);
        add_op(OP_INC, 32'sh7FFFFFFF, 32'sh0);
        add_op(OP_DEC, 32'sh80000000, 32'sh0);
        add_op(OP_FROM_INT, 32'sh00800000, 32'sh5);
        add_op(OP_FROM_INT, -32'sh00800001, 32'sh5);
        add_op(OP_TO_INT, -32'sh1, 32'sh0);
        add_op(OP_TO_INT, 32'sh7FFFFFFF, -32'sh1);
        add_op(4'd10, 32'sh5, 32'sh5);
        add_op(4'd15, -32'sh1, 32'sh1);
        add_op(OP_ADD, 32'shFFFFFFFF, 32'shFFFFFFFF);
        add_op(OP_ADD, 32'sh0, 32'sh0);

        add_random(300);
        drain_all();

        // The sender stops partway through a burst until every result is back.
        add_random(20);
        while (pending_ops.size() > 10)
            @(posedge clk);
        hold_sender = 1'b1;
        while (req.valid || expected_results.size() > 0)
            @(posedge clk);
        hold_sender = 1'b0;
        drain_all();

        send_idle_pct = 61;
        recv_idle_pct = 28;
        add_random(280);
        drain_all();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(280);
        drain_all();

        repeat (LATENCY + 10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("ERROR: %0d expected results never arrived", expected_results.size());
            mismatches++;
        end
        $display("Covered %0d operations and %0d result beats, all opcodes, under three",
                 ops_sent, results_seen);
        $display("stall mixes with saturation, divide by zero and rounding ties.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timeout");
        $display("Mismatches found");
        $finish;
    end
endmodule

// ===== filelist.f =====
hdl/fpa_pkg.sv
hdl/fpa_if.sv
hdl/fpa_div.sv
hdl/fixed_point_alu.sv
bench/fixed_point_alu_test.sv
